/* design/olir_pkg.sv */
// Shared types and codes for the ordered list insert/remove unit.
package olir_pkg;

  localparam int VAL_W = 32;
  localparam int IDX_W = 8;
  localparam int POS_W = 8;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_LIST   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] index;
    logic             last;
  } result_t;

endpackage

/* design/olir_ram.sv */
// Entry storage: one write port, one registered read port.
module olir_ram #(
  parameter int DEPTH = 16,
  parameter int AW = 4
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [olir_pkg::VAL_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [olir_pkg::VAL_W-1:0] rdata
);

  logic [olir_pkg::VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/olir_out.sv */
// Output register holding one result item until it is taken.
module olir_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  olir_pkg::result_t din,
  input  logic              out_ready,
  output logic              out_valid,
  output olir_pkg::result_t dout,
  output logic              can_load
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dout <= din;
    end
  end

endmodule

/* design/ordered_list_insert_remove_unit.sv */
// Ordered list unit top level: command sequencer, entry memory and output register.
// Keeps up to CAPACITY signed 32-bit values in order. in_ready is high only while the
// sequencer is idle. An insert moves each entry from the insert position to the tail one
// place toward the tail and then writes the new value; a remove scans the whole list and
// moves each entry after the match one place toward the head; a list command emits every
// entry in turn. A refused insert, a remove on an empty list or a list of an empty list
// gives a single status result; an unused command code gives no result.
// Each command works through the single registered read port of the entry memory: each
// entry is read in one cycle and compared, moved or emitted in the next. A result
// waits in the output register, and the next item is accepted while it waits; the
// sequencer stalls only when a new result meets a full output register.
module ordered_list_insert_remove_unit #(
  parameter int CAPACITY = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        command,
  input  logic signed [olir_pkg::VAL_W-1:0] item_value,
  input  logic [olir_pkg::POS_W-1:0]        position,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic signed [olir_pkg::VAL_W-1:0] entry_value,
  output logic [olir_pkg::IDX_W-1:0]        entry_index,
  output logic                              last
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS_RD  = 4'd1;
  localparam logic [3:0] S_INS_WR  = 4'd2;
  localparam logic [3:0] S_REM_RD  = 4'd3;
  localparam logic [3:0] S_REM_CHK = 4'd4;
  localparam logic [3:0] S_REM_END = 4'd5;
  localparam logic [3:0] S_LST_RD  = 4'd6;
  localparam logic [3:0] S_LST_OUT = 4'd7;
  localparam logic [3:0] S_RES     = 4'd8;

  logic [3:0]                  state, state_next;
  logic [CW-1:0]               count, count_next;
  logic [CW-1:0]               idx, idx_next;
  logic [CW-1:0]               at, at_next;
  logic [olir_pkg::VAL_W-1:0]  value, value_next;
  logic                        found, found_next;
  logic [1:0]                  res_status, res_status_next;

  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [olir_pkg::VAL_W-1:0]  ram_wdata, ram_rdata;

  logic                        out_load, out_can_load;
  olir_pkg::result_t           out_din, out_dout;

  logic [CW-1:0]               idx_inc, idx_dec;
  logic [olir_pkg::POS_W-1:0]  pos_at, count_ext;
  logic                        accept;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign idx_inc   = idx + CW'(1);
  assign idx_dec   = idx - CW'(1);
  assign count_ext = olir_pkg::POS_W'(count);
  assign pos_at    = (position <= olir_pkg::POS_W'(1)) ? '0 : position - olir_pkg::POS_W'(1);

  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    at_next         = at;
    value_next      = value;
    found_next      = found;
    res_status_next = res_status;
    ram_we          = 1'b0;
    ram_waddr       = idx[AW-1:0];
    ram_wdata       = ram_rdata;
    ram_re          = 1'b0;
    ram_raddr       = idx[AW-1:0];
    out_load        = 1'b0;
    out_din         = '0;
    out_din.status  = res_status;
    out_din.last    = 1'b1;

    case (state)
      S_IDLE: begin
        if (accept) begin
          value_next = item_value;
          found_next = 1'b0;
          idx_next   = '0;
          case (command)
            olir_pkg::CMD_INSERT: begin
              if (count == CW'(CAPACITY)) begin
                res_status_next = olir_pkg::ST_FULL;
                state_next      = S_RES;
              end else begin
                at_next    = (pos_at > count_ext) ? count : CW'(pos_at);
                idx_next   = count;
                state_next = S_INS_RD;
              end
            end
            olir_pkg::CMD_REMOVE: begin
              if (count == '0) begin
                res_status_next = olir_pkg::ST_NOT_FOUND;
                state_next      = S_RES;
              end else begin
                state_next = S_REM_RD;
              end
            end
            olir_pkg::CMD_LIST: begin
              if (count == '0) begin
                res_status_next = olir_pkg::ST_EMPTY;
                state_next      = S_RES;
              end else begin
                state_next = S_LST_RD;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_INS_RD: begin
        if (idx > at) begin
          ram_re     = 1'b1;
          ram_raddr  = idx_dec[AW-1:0];
          state_next = S_INS_WR;
        end else begin
          ram_we          = 1'b1;
          ram_waddr       = at[AW-1:0];
          ram_wdata       = value;
          count_next      = count + CW'(1);
          res_status_next = olir_pkg::ST_OK;
          state_next      = S_RES;
        end
      end
      S_INS_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = idx[AW-1:0];
        idx_next   = idx_dec;
        state_next = S_INS_RD;
      end
      S_REM_RD: begin
        ram_re     = 1'b1;
        state_next = S_REM_CHK;
      end
      S_REM_CHK: begin
        if (found) begin
          ram_we    = 1'b1;
          ram_waddr = idx_dec[AW-1:0];
        end else if (ram_rdata == value) begin
          found_next = 1'b1;
        end
        idx_next   = idx_inc;
        state_next = (idx_inc == count) ? S_REM_END : S_REM_RD;
      end
      S_REM_END: begin
        if (found) begin
          count_next      = count - CW'(1);
          res_status_next = olir_pkg::ST_OK;
        end else begin
          res_status_next = olir_pkg::ST_NOT_FOUND;
        end
        state_next = S_RES;
      end
      S_LST_RD: begin
        ram_re     = 1'b1;
        state_next = S_LST_OUT;
      end
      S_LST_OUT: begin
        out_din.status = olir_pkg::ST_OK;
        out_din.value  = ram_rdata;
        out_din.index  = olir_pkg::IDX_W'(idx);
        out_din.last   = (idx_inc == count);
        if (out_can_load) begin
          out_load = 1'b1;
          if (idx_inc == count) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = idx_inc;
            state_next = S_LST_RD;
          end
        end
      end
      S_RES: begin
        if (out_can_load) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    at         <= at_next;
    value      <= value_next;
    found      <= found_next;
    res_status <= res_status_next;
  end

  olir_ram #(
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  olir_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (out_load),
    .din      (out_din),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .dout     (out_dout),
    .can_load (out_can_load)
  );

  assign status      = out_dout.status;
  assign entry_value = out_dout.value;
  assign entry_index = out_dout.index;
  assign last        = out_dout.last;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_load_safe: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_can_load)
    else $error("result loaded over an untaken item");

  a_idle_count_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |=> (count == $past(count)))
    else $error("entry count changed while idle");

  a_no_write_when_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !ram_we)
    else $error("memory written while idle");

endmodule
